/* rtl/xbr_pkg.sv */
`default_nettype none
package xbr_pkg;

    localparam logic [7:0] B_SOH  = 8'h01;
    localparam logic [7:0] B_STX  = 8'h02;
    localparam logic [7:0] B_EOT  = 8'h04;
    localparam logic [7:0] B_ACK  = 8'h06;
    localparam logic [7:0] B_NAK  = 8'h15;
    localparam logic [7:0] B_CAN  = 8'h18;
    localparam logic [7:0] B_POLL = 8'h43;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [23:0] TICK_MAX = 24'hffffff;
    localparam int          DESC_OFF_BITS = 32;

    typedef enum logic [3:0] {
        PH_IDLE, PH_HDR, PH_NUM, PH_CMP, PH_DATA, PH_CHK1, PH_CHK2,
        PH_FL_TRY, PH_FL_TMO, PH_FL_MIS, PH_FL_SYNC
    } phase_t;

    typedef enum logic [1:0] {PC_NONE, PC_EOT, PC_CAN} prev_char_t;

    typedef enum logic [1:0] {MODE_BYTE, MODE_TICK, MODE_START, MODE_UNUSED} mode_t;

    typedef enum logic [2:0] {
        ST_RUNNING, ST_DONE, ST_ABORT, ST_MISMATCH, ST_TIMEOUT, ST_SYNC, ST_TRUNC
    } status_t;

    typedef enum logic [2:0] {
        CFG_CRC_MODE, CFG_YMODEM_BATCH, CFG_HDR_TIMEOUT, CFG_CHAR_TIMEOUT,
        CFG_RETRY_MAX, CFG_EXPECTED_SIZE
    } cfg_index_t;

    // One accepted item's worth of results, expanded later by the back end.
    typedef struct packed {
        logic [2:0]               tx_n;
        logic [7:0]               tx_a;
        logic [7:0]               tx_b;
        logic                     wr_v;
        logic [DESC_OFF_BITS-1:0] wr_off;
        logic [7:0]               wr_byte;
        status_t                  status;
    } desc_t;

    function automatic logic [15:0] crc_byte(logic [15:0] c_in, logic [7:0] b);
        logic [15:0] c;
        logic        msb;
        c = c_in;
        for (int i = 7; i >= 0; i--) begin
            msb = c[15];
            c = {c[14:0], b[i]};
            if (msb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/xbr_if.sv */
`default_nettype none
interface xbr_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;
    modport source (output valid, mode, rx_byte, input ready);
    modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface xbr_res_if #(parameter int OFFSET_BITS = 24);
    logic                   valid;
    logic                   ready;
    logic                   tx_valid;
    logic [7:0]             tx_byte;
    logic                   wr_valid;
    logic [OFFSET_BITS-1:0] wr_offset;
    logic [7:0]             wr_byte;
    logic [2:0]             status;
    logic                   last;
    modport source (output valid, tx_valid, tx_byte, wr_valid, wr_offset, wr_byte, status,
                    last, input ready);
    modport sink (input valid, tx_valid, tx_byte, wr_valid, wr_offset, wr_byte, status,
                  last, output ready);
endinterface

interface xbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/xbr_front.sv */
`default_nettype none
module xbr_front #(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_ok,
    input  wire logic [1:0]    mode,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          cfg_ok,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [23:0]   cfg_data,
    output xbr_pkg::desc_t     desc,
    output logic               push
);
    localparam int OB = OFFSET_BITS;
    localparam int CW = (OB > 24) ? OB : 24;
    localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};

    logic        crc_mode_reg, ymodem_reg;
    logic [23:0] hdr_to_reg, chr_to_reg, exp_size_reg;
    logic [7:0]  retry_max_reg;

    xbr_pkg::phase_t     phase_reg, phase_next;
    xbr_pkg::prev_char_t prev_reg, prev_next;
    logic [7:0]  exp_blk_reg, exp_blk_next, got_blk_reg, got_blk_next;
    logic [10:0] idx_reg, idx_next;
    logic        long_reg, long_next, first_reg, first_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  sum_reg, sum_next, tries_reg, tries_next, sync_reg, sync_next;
    logic [7:0]  peb_reg, peb_next;
    logic [23:0] tick_reg, tick_next;
    logic [OB-1:0] bstart_reg, bstart_next, fbytes_reg, fbytes_next;

    function automatic xbr_pkg::desc_t add_tx(xbr_pkg::desc_t d_in, logic [7:0] b);
        xbr_pkg::desc_t d;
        d = d_in;
        if (d.tx_n == 3'd0)
        begin
            d.tx_a = b;
        end
        else
        begin
            d.tx_b = b;
        end
        d.tx_n = d.tx_n + 3'd1;
        return d;
    endfunction

    function automatic logic [OB-1:0] sat_add(logic [OB-1:0] a, logic [OB-1:0] b);
        logic [OB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[OB] ? OFF_MAX : s[OB-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_mode_reg  <= 1'b0;
            ymodem_reg    <= 1'b0;
            hdr_to_reg    <= 24'd1000000;
            chr_to_reg    <= 24'd100000;
            retry_max_reg <= 8'd10;
            exp_size_reg  <= 24'd0;
        end
        else if (cfg_ok)
        begin
            unique case (xbr_pkg::cfg_index_t'(cfg_index))
                xbr_pkg::CFG_CRC_MODE:      crc_mode_reg  <= cfg_data[0];
                xbr_pkg::CFG_YMODEM_BATCH:  ymodem_reg    <= cfg_data[0];
                xbr_pkg::CFG_HDR_TIMEOUT:   hdr_to_reg    <= cfg_data;
                xbr_pkg::CFG_CHAR_TIMEOUT:  chr_to_reg    <= cfg_data;
                xbr_pkg::CFG_RETRY_MAX:     retry_max_reg <= cfg_data[7:0];
                xbr_pkg::CFG_EXPECTED_SIZE: exp_size_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= xbr_pkg::PH_IDLE;
            prev_reg    <= xbr_pkg::PC_NONE;
            exp_blk_reg <= '0;
            got_blk_reg <= '0;
            idx_reg     <= '0;
            long_reg    <= 1'b0;
            first_reg   <= 1'b1;
            crc_reg     <= '0;
            sum_reg     <= '0;
            tries_reg   <= '0;
            sync_reg    <= '0;
            peb_reg     <= '0;
            tick_reg    <= '0;
            bstart_reg  <= '0;
            fbytes_reg  <= '0;
        end
        else if (item_ok)
        begin
            phase_reg   <= phase_next;
            prev_reg    <= prev_next;
            exp_blk_reg <= exp_blk_next;
            got_blk_reg <= got_blk_next;
            idx_reg     <= idx_next;
            long_reg    <= long_next;
            first_reg   <= first_next;
            crc_reg     <= crc_next;
            sum_reg     <= sum_next;
            tries_reg   <= tries_next;
            sync_reg    <= sync_next;
            peb_reg     <= peb_next;
            tick_reg    <= tick_next;
            bstart_reg  <= bstart_next;
            fbytes_reg  <= fbytes_next;
        end
    end

    logic [OB-1:0] blen;
    logic [10:0]   blen_idx;
    assign blen_idx = long_reg ? 11'd1024 : 11'd128;
    assign blen     = OB'(blen_idx);

    always_comb
    begin
        xbr_pkg::desc_t d;
        logic           bt, clr, done, fin, fin_cans;
        xbr_pkg::status_t fin_st;
        logic [23:0]    lim, tinc;
        logic [7:0]     t, n;
        logic [15:0]    c;

        phase_next   = phase_reg;
        prev_next    = prev_reg;
        exp_blk_next = exp_blk_reg;
        got_blk_next = got_blk_reg;
        idx_next     = idx_reg;
        long_next    = long_reg;
        first_next   = first_reg;
        crc_next     = crc_reg;
        sum_next     = sum_reg;
        tries_next   = tries_reg;
        sync_next    = sync_reg;
        peb_next     = peb_reg;
        tick_next    = tick_reg;
        bstart_next  = bstart_reg;
        fbytes_next  = fbytes_reg;
        d        = '0;
        bt       = 1'b0;
        clr      = 1'b0;
        done     = 1'b0;
        fin      = 1'b0;
        fin_cans = 1'b0;
        fin_st   = xbr_pkg::ST_RUNNING;
        lim      = (phase_reg == xbr_pkg::PH_HDR) ? hdr_to_reg : chr_to_reg;
        tinc     = (tick_reg == xbr_pkg::TICK_MAX) ? tick_reg : tick_reg + 24'd1;
        c        = xbr_pkg::crc_byte(crc_reg, rx_byte);
        t        = '0;
        n        = got_blk_reg;

        unique case (xbr_pkg::mode_t'(mode))
            xbr_pkg::MODE_START:
            begin
                exp_blk_next = '0;
                first_next   = 1'b1;
                fbytes_next  = '0;
                bstart_next  = '0;
                peb_next     = '0;
                sync_next    = '0;
                clr = 1'b1;
                bt  = 1'b1;
            end
            xbr_pkg::MODE_TICK:
            begin
                if (phase_reg != xbr_pkg::PH_IDLE)
                begin
                    tick_next = tinc;
                    if (tinc >= lim)
                    begin
                        unique case (phase_reg)
                            xbr_pkg::PH_HDR:
                            begin
                                prev_next  = xbr_pkg::PC_NONE;
                                phase_next = xbr_pkg::PH_FL_TRY;
                                tick_next  = '0;
                            end
                            xbr_pkg::PH_NUM, xbr_pkg::PH_CMP, xbr_pkg::PH_DATA,
                            xbr_pkg::PH_CHK1, xbr_pkg::PH_CHK2:
                            begin
                                phase_next = xbr_pkg::PH_FL_TRY;
                                tick_next  = '0;
                            end
                            xbr_pkg::PH_FL_TRY: bt = 1'b1;
                            xbr_pkg::PH_FL_TMO:
                            begin
                                fin = 1'b1; fin_cans = 1'b1; fin_st = xbr_pkg::ST_TIMEOUT;
                            end
                            xbr_pkg::PH_FL_MIS:
                            begin
                                fin = 1'b1; fin_cans = 1'b1; fin_st = xbr_pkg::ST_MISMATCH;
                            end
                            xbr_pkg::PH_FL_SYNC:
                            begin
                                fin = 1'b1; fin_cans = 1'b1; fin_st = xbr_pkg::ST_SYNC;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            xbr_pkg::MODE_BYTE:
            begin
                if (phase_reg != xbr_pkg::PH_IDLE)
                begin
                    tick_next = '0;
                    unique case (phase_reg)
                        xbr_pkg::PH_HDR:
                        begin
                            if (rx_byte == xbr_pkg::B_SOH || rx_byte == xbr_pkg::B_STX)
                            begin
                                long_next  = (rx_byte == xbr_pkg::B_STX);
                                prev_next  = xbr_pkg::PC_NONE;
                                phase_next = xbr_pkg::PH_NUM;
                            end
                            else if (rx_byte == xbr_pkg::B_EOT)
                            begin
                                if (prev_reg == xbr_pkg::PC_EOT)
                                begin
                                    fin = 1'b1;
                                    if (exp_size_reg != 24'd0 &&
                                        CW'(fbytes_reg) < CW'(exp_size_reg))
                                    begin
                                        fin_cans = 1'b1;
                                        fin_st   = xbr_pkg::ST_TRUNC;
                                    end
                                    else
                                    begin
                                        d      = add_tx(d, xbr_pkg::B_ACK);
                                        fin_st = xbr_pkg::ST_DONE;
                                    end
                                end
                                else
                                begin
                                    prev_next  = xbr_pkg::PC_EOT;
                                    phase_next = xbr_pkg::PH_FL_TRY;
                                    tick_next  = '0;
                                end
                            end
                            else if (rx_byte == xbr_pkg::B_CAN)
                            begin
                                if (prev_reg == xbr_pkg::PC_CAN)
                                begin
                                    fin    = 1'b1;
                                    fin_st = xbr_pkg::ST_ABORT;
                                end
                                else
                                begin
                                    prev_next = xbr_pkg::PC_CAN;
                                    bt = 1'b1;
                                end
                            end
                            else
                            begin
                                prev_next  = xbr_pkg::PC_NONE;
                                phase_next = xbr_pkg::PH_FL_TRY;
                            end
                        end
                        xbr_pkg::PH_NUM:
                        begin
                            got_blk_next = rx_byte;
                            phase_next   = xbr_pkg::PH_CMP;
                        end
                        xbr_pkg::PH_CMP:
                        begin
                            if (got_blk_reg + rx_byte == 8'hff)
                            begin
                                idx_next   = '0;
                                crc_next   = '0;
                                sum_next   = '0;
                                phase_next = xbr_pkg::PH_DATA;
                            end
                            else
                            begin
                                phase_next = xbr_pkg::PH_FL_TRY;
                            end
                        end
                        xbr_pkg::PH_DATA:
                        begin
                            d.wr_v    = 1'b1;
                            d.wr_off  = xbr_pkg::DESC_OFF_BITS'(sat_add(bstart_reg, OB'(idx_reg)));
                            d.wr_byte = rx_byte;
                            sum_next  = sum_reg + rx_byte;
                            crc_next  = c;
                            idx_next  = idx_reg + 11'd1;
                            if (idx_next >= blen_idx)
                            begin
                                phase_next = xbr_pkg::PH_CHK1;
                            end
                        end
                        xbr_pkg::PH_CHK1:
                        begin
                            if (crc_mode_reg)
                            begin
                                crc_next   = c;
                                phase_next = xbr_pkg::PH_CHK2;
                            end
                            else if (sum_reg == rx_byte)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                phase_next = xbr_pkg::PH_FL_TRY;
                            end
                        end
                        xbr_pkg::PH_CHK2:
                        begin
                            crc_next = c;
                            if (c == 16'd0)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                phase_next = xbr_pkg::PH_FL_TRY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        // Block number disposition once a block has checked good.
        if (done)
        begin
            if (n == exp_blk_reg + 8'd1)
            begin
                exp_blk_next = n;
                fbytes_next  = sat_add(fbytes_reg, blen);
                bstart_next  = sat_add(bstart_reg, blen);
                first_next   = 1'b0;
                peb_next     = '0;
                sync_next    = '0;
                d  = add_tx(d, xbr_pkg::B_ACK);
                clr = 1'b1;
                bt  = 1'b1;
            end
            else if (n == exp_blk_reg)
            begin
                if (!ymodem_reg && n == 8'd0)
                begin
                    d = add_tx(d, xbr_pkg::B_NAK);
                    phase_next = xbr_pkg::PH_FL_MIS;
                    tick_next  = '0;
                end
                else
                begin
                    peb_next  = '0;
                    sync_next = '0;
                    d  = add_tx(d, xbr_pkg::B_ACK);
                    clr = 1'b1;
                    bt  = 1'b1;
                end
            end
            else
            begin
                if (n == peb_reg)
                begin
                    sync_next = sync_reg + 8'd1;
                end
                peb_next = n;
                d = add_tx(d, xbr_pkg::B_NAK);
                if (sync_next == retry_max_reg)
                begin
                    phase_next = xbr_pkg::PH_FL_SYNC;
                    tick_next  = '0;
                end
                else
                begin
                    clr = 1'b1;
                    bt  = 1'b1;
                end
            end
        end

        // Start of the next try, the last action of every path that reaches it.
        if (bt)
        begin
            t = clr ? 8'd0 : tries_reg;
            if (clr)
            begin
                prev_next = xbr_pkg::PC_NONE;
            end
            tick_next = '0;
            if (t >= retry_max_reg)
            begin
                tries_next = t;
                phase_next = xbr_pkg::PH_FL_TMO;
            end
            else
            begin
                tries_next = t + 8'd1;
                if (first_next)
                begin
                    d = add_tx(d, crc_mode_reg ? xbr_pkg::B_POLL : xbr_pkg::B_NAK);
                end
                else if (tries_next > 8'd1)
                begin
                    d = add_tx(d, xbr_pkg::B_NAK);
                end
                phase_next = xbr_pkg::PH_HDR;
            end
        end

        if (fin)
        begin
            if (fin_cans)
            begin
                d.tx_n = 3'd4;
                d.tx_a = xbr_pkg::B_CAN;
                d.tx_b = xbr_pkg::B_CAN;
            end
            d.status   = fin_st;
            phase_next = xbr_pkg::PH_IDLE;
        end

        desc = d;
        push = item_ok && (fin || d.wr_v || d.tx_n != 3'd0);
    end

    a_desc_count: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (desc.tx_n <= 3'd4 && !(desc.wr_v && desc.tx_n != 3'd0)))
        else $error("front produced an impossible result set");

endmodule
`default_nettype wire

/* rtl/xbr_queue.sv */
`default_nettype none
module xbr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  xbr_pkg::desc_t      push_desc,
    input  wire logic           pop,
    output xbr_pkg::desc_t      head,
    output logic                not_empty,
    output logic                full
);
    xbr_pkg::desc_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign head      = mem_reg[rp_reg];
    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("queue read while empty");

endmodule
`default_nettype wire

/* rtl/xbr_back.sv */
`default_nettype none
module xbr_back #(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  xbr_pkg::desc_t        head,
    input  wire logic             not_empty,
    output logic                  pop,
    xbr_res_if.source             res
);
    logic [2:0] k_reg, k_next;
    logic [2:0] total;
    logic       is_last, take;

    assign total   = (head.wr_v || head.tx_n == 3'd0) ? 3'd1 : head.tx_n;
    assign is_last = (k_reg == total - 3'd1);
    assign take    = res.valid && res.ready;
    assign pop     = take && is_last;
    assign k_next  = pop ? 3'd0 : (take ? k_reg + 3'd1 : k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= 3'd0;
        end
        else
        begin
            k_reg <= k_next;
        end
    end

    assign res.valid     = not_empty;
    assign res.tx_valid  = (k_reg < head.tx_n);
    assign res.tx_byte   = (k_reg == 3'd0) ? head.tx_a : head.tx_b;
    assign res.wr_valid  = head.wr_v;
    assign res.wr_offset = head.wr_off[OFFSET_BITS-1:0];
    assign res.wr_byte   = head.wr_byte;
    assign res.status    = head.status;
    assign res.last      = is_last;

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        not_empty |-> (k_reg < total))
        else $error("result index ran past the item's result count");

endmodule
`default_nettype wire

/* rtl/xmodem_block_receiver_top.sv */
`default_nettype none
// XMODEM block receiver. Each command item is a received byte, a timer tick or a
// start request; each result item is one byte to send to the sender (ACK, NAK, 'C'
// or CAN), one payload write at a file offset, or a bare status report, and the
// last result of a command carries last. The front end runs the protocol state
// machine and hands a summary of up to four results to a two-entry queue; the
// back end then presents those results one per cycle while res.ready is high,
// and a new command is taken every cycle as long as the queue has room.
// Configuration registers are written through the cfg channel, which is always
// ready, and must only be changed while no transfer work is pending.
module xmodem_block_receiver_top #(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    xbr_cmd_if.sink   cmd,
    xbr_cfg_if.sink   cfg,
    xbr_res_if.source res
);
    xbr_pkg::desc_t front_desc, head;
    logic           push, pop, not_empty, full, item_ok;

    assign cmd.ready = !full;
    assign cfg.ready = 1'b1;
    assign item_ok   = cmd.valid && !full;

    xbr_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ok   (item_ok),
        .mode      (cmd.mode),
        .rx_byte   (cmd.rx_byte),
        .cfg_ok    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .desc      (front_desc),
        .push      (push)
    );

    xbr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (front_desc),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    xbr_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .res       (res)
    );

endmodule
`default_nettype wire

/* sim/xbr_checker.sv */
`default_nettype none
module xbr_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    xbr_cmd_if        cmd,
    xbr_cfg_if        cfg,
    xbr_res_if        res,
    output int        fails,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import xbr_pkg::*;

    typedef struct {
        logic        txv;
        logic [7:0]  tx;
        logic        wrv;
        logic [23:0] off;
        logic [7:0]  wb;
        logic [2:0]  status;
        logic        last;
    } reply_t;

    // Configuration copy.
    logic        m_crc;
    logic        m_batch;
    logic [23:0] m_hdr_to;
    logic [23:0] m_chr_to;
    logic [7:0]  m_retry;
    logic [23:0] m_size;

    // Protocol state copy.
    phase_t      ph;
    prev_char_t  prev_ch;
    logic [7:0]  exp_blk, got_blk, got_cmp, crc_chk_first, tries, sync_err, sum_acc;
    logic [8:0]  prev_err;
    logic [10:0] bidx;
    logic        long_blk, first_blk;
    logic [15:0] crc_acc;
    logic [23:0] ticks, blk_start, file_bytes;

    reply_t      item_replies[$];
    reply_t      expected_replies[$];
    logic [2:0]  item_status;

    function automatic void put(logic txv, logic [7:0] tx, logic wrv, logic [23:0] off,
                                logic [7:0] wb);
        reply_t r;
        r.txv = txv;
        r.tx = txv ? tx : 8'h00;
        r.wrv = wrv;
        r.off = wrv ? off : 24'h0;
        r.wb = wrv ? wb : 8'h00;
        r.status = ST_RUNNING;
        r.last = 1'b0;
        if (item_replies.size() < 5)
        begin
            item_replies.push_back(r);
        end
    endfunction

    function automatic void put_tx(logic [7:0] b);
        put(1'b1, b, 1'b0, 24'h0, 8'h00);
    endfunction

    function automatic logic [23:0] sat_sum(logic [23:0] a, logic [10:0] b);
        logic [25:0] s;
        s = {2'b00, a} + {15'h0, b};
        return (s > 26'hffffff) ? 24'hffffff : s[23:0];
    endfunction

    // Bit-serial division: data bits are shifted in at the bottom, so a block
    // followed by its own check value leaves a zero remainder.
    function automatic logic [15:0] crc_shift(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        logic        top;
        r = c;
        for (int i = 7; i >= 0; i--)
        begin
            top = r[15];
            r = {r[14:0], b[i]};
            if (top)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic logic [10:0] blk_len();
        return long_blk ? 11'd1024 : 11'd128;
    endfunction

    function automatic void enter_flush(phase_t p);
        ph = p;
        ticks = 24'h0;
    endfunction

    function automatic void end_transfer(logic [2:0] st, logic cans);
        if (cans)
        begin
            repeat (4) put_tx(B_CAN);
        end
        if (item_replies.size() == 0)
        begin
            put(1'b0, 8'h00, 1'b0, 24'h0, 8'h00);
        end
        item_status = st;
        ph = PH_IDLE;
    endfunction

    function automatic void start_try();
        if (tries >= m_retry)
        begin
            enter_flush(PH_FL_TMO);
            return;
        end
        tries = tries + 8'd1;
        if (first_blk)
        begin
            put_tx(m_crc ? B_POLL : B_NAK);
        end
        else if (tries > 8'd1)
        begin
            put_tx(B_NAK);
        end
        ph = PH_HDR;
        ticks = 24'h0;
    endfunction

    function automatic void fresh_block();
        tries = 8'h0;
        prev_ch = PC_NONE;
        start_try();
    endfunction

    function automatic void close_block(logic [7:0] n);
        if (n == exp_blk + 8'd1)
        begin
            exp_blk = n;
            file_bytes = sat_sum(file_bytes, blk_len());
            blk_start = sat_sum(blk_start, blk_len());
            first_blk = 1'b0;
            prev_err = 9'h0;
            sync_err = 8'h0;
            put_tx(B_ACK);
            fresh_block();
        end
        else if (n == exp_blk)
        begin
            if (!m_batch && n == 8'h00)
            begin
                put_tx(B_NAK);
                enter_flush(PH_FL_MIS);
                return;
            end
            prev_err = 9'h0;
            sync_err = 8'h0;
            put_tx(B_ACK);
            fresh_block();
        end
        else
        begin
            if ({1'b0, n} == prev_err)
            begin
                sync_err = sync_err + 8'd1;
            end
            prev_err = {1'b0, n};
            put_tx(B_NAK);
            if (sync_err == m_retry)
            begin
                enter_flush(PH_FL_SYNC);
            end
            else
            begin
                fresh_block();
            end
        end
    endfunction

    function automatic void expire();
        case (ph)
            PH_HDR:
            begin
                prev_ch = PC_NONE;
                enter_flush(PH_FL_TRY);
            end
            PH_NUM, PH_CMP, PH_DATA, PH_CHK1, PH_CHK2: enter_flush(PH_FL_TRY);
            PH_FL_TRY:  start_try();
            PH_FL_TMO:  end_transfer(ST_TIMEOUT, 1'b1);
            PH_FL_MIS:  end_transfer(ST_MISMATCH, 1'b1);
            PH_FL_SYNC: end_transfer(ST_SYNC, 1'b1);
            default: ;
        endcase
    endfunction

    function automatic void take_byte(logic [7:0] b);
        ticks = 24'h0;
        case (ph)
            PH_HDR:
            begin
                if (b == B_SOH || b == B_STX)
                begin
                    long_blk = (b == B_STX);
                    prev_ch = PC_NONE;
                    ph = PH_NUM;
                end
                else if (b == B_EOT)
                begin
                    if (prev_ch == PC_EOT)
                    begin
                        if (m_size != 24'h0 && file_bytes < m_size)
                        begin
                            end_transfer(ST_TRUNC, 1'b1);
                        end
                        else
                        begin
                            put_tx(B_ACK);
                            end_transfer(ST_DONE, 1'b0);
                        end
                    end
                    else
                    begin
                        prev_ch = PC_EOT;
                        enter_flush(PH_FL_TRY);
                    end
                end
                else if (b == B_CAN)
                begin
                    if (prev_ch == PC_CAN)
                    begin
                        end_transfer(ST_ABORT, 1'b0);
                    end
                    else
                    begin
                        prev_ch = PC_CAN;
                        start_try();
                    end
                end
                else
                begin
                    prev_ch = PC_NONE;
                    enter_flush(PH_FL_TRY);
                end
            end
            PH_NUM:
            begin
                got_blk = b;
                ph = PH_CMP;
            end
            PH_CMP:
            begin
                got_cmp = b;
                if (got_blk + got_cmp == 8'hff)
                begin
                    bidx = 11'h0;
                    crc_acc = 16'h0;
                    sum_acc = 8'h0;
                    ph = PH_DATA;
                end
                else
                begin
                    enter_flush(PH_FL_TRY);
                end
            end
            PH_DATA:
            begin
                put(1'b0, 8'h00, 1'b1, sat_sum(blk_start, bidx), b);
                sum_acc = sum_acc + b;
                crc_acc = crc_shift(crc_acc, b);
                bidx = bidx + 11'd1;
                if (bidx >= blk_len())
                begin
                    ph = PH_CHK1;
                end
            end
            PH_CHK1:
            begin
                crc_chk_first = b;
                if (m_crc)
                begin
                    crc_acc = crc_shift(crc_acc, b);
                    ph = PH_CHK2;
                end
                else if (sum_acc == crc_chk_first)
                begin
                    close_block(got_blk);
                end
                else
                begin
                    enter_flush(PH_FL_TRY);
                end
            end
            PH_CHK2:
            begin
                crc_acc = crc_shift(crc_acc, b);
                if (crc_acc == 16'h0)
                begin
                    close_block(got_blk);
                end
                else
                begin
                    enter_flush(PH_FL_TRY);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_item(logic [1:0] m, logic [7:0] b);
        logic [23:0] lim;
        item_replies.delete();
        item_status = ST_RUNNING;
        if (m == MODE_START)
        begin
            exp_blk = 8'h0;
            first_blk = 1'b1;
            file_bytes = 24'h0;
            blk_start = 24'h0;
            prev_err = 9'h0;
            sync_err = 8'h0;
            fresh_block();
        end
        else if (m == MODE_BYTE)
        begin
            if (ph != PH_IDLE)
            begin
                take_byte(b);
            end
        end
        else if (m == MODE_TICK)
        begin
            if (ph != PH_IDLE)
            begin
                lim = (ph == PH_HDR) ? m_hdr_to : m_chr_to;
                if (ticks < TICK_MAX)
                begin
                    ticks = ticks + 24'd1;
                end
                if (ticks >= lim)
                begin
                    expire();
                end
            end
        end
        foreach (item_replies[k])
        begin
            item_replies[k].status = item_status;
            item_replies[k].last = (k == item_replies.size() - 1);
            expected_replies.push_back(item_replies[k]);
        end
    endfunction

    function automatic void reset_model();
        m_crc = 1'b0;
        m_batch = 1'b0;
        m_hdr_to = 24'd1000000;
        m_chr_to = 24'd100000;
        m_retry = 8'd10;
        m_size = 24'h0;
        ph = PH_IDLE;
        prev_ch = PC_NONE;
        exp_blk = 8'h0;
        got_blk = 8'h0;
        got_cmp = 8'h0;
        crc_chk_first = 8'h0;
        tries = 8'h0;
        sync_err = 8'h0;
        sum_acc = 8'h0;
        prev_err = 9'h0;
        bidx = 11'h0;
        long_blk = 1'b0;
        first_blk = 1'b1;
        crc_acc = 16'h0;
        ticks = 24'h0;
        blk_start = 24'h0;
        file_bytes = 24'h0;
    endfunction

    always @(posedge clk)
    begin
        reply_t e;
        if (!rst_n)
        begin
            fails = 0;
            reset_model();
            expected_replies.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_CRC_MODE:      m_crc = cfg.data[0];
                    CFG_YMODEM_BATCH:  m_batch = cfg.data[0];
                    CFG_HDR_TIMEOUT:   m_hdr_to = cfg.data;
                    CFG_CHAR_TIMEOUT:  m_chr_to = cfg.data;
                    CFG_RETRY_MAX:     m_retry = cfg.data[7:0];
                    CFG_EXPECTED_SIZE: m_size = cfg.data;
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready)
            begin
                predict_item(cmd.mode, cmd.rx_byte);
            end
            if (res.valid && res.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected result item tx=%h wr=%h", res.tx_byte, res.wr_byte);
                    fails++;
                end
                else
                begin
                    e = expected_replies.pop_front();
                    if (res.tx_valid !== e.txv || res.tx_byte !== e.tx
                        || res.wr_valid !== e.wrv || res.wr_offset !== e.off
                        || res.wr_byte !== e.wb || res.status !== e.status
                        || res.last !== e.last)
                    begin
                        fails++;
                        if (res.tx_valid !== e.txv)
                            $error("tx_valid exp %h got %h", e.txv, res.tx_valid);
                        if (res.tx_byte !== e.tx)
                            $error("tx_byte exp %h got %h", e.tx, res.tx_byte);
                        if (res.wr_valid !== e.wrv)
                            $error("wr_valid exp %h got %h", e.wrv, res.wr_valid);
                        if (res.wr_offset !== e.off)
                            $error("wr_offset exp %h got %h", e.off, res.wr_offset);
                        if (res.wr_byte !== e.wb)
                            $error("wr_byte exp %h got %h", e.wb, res.wr_byte);
                        if (res.status !== e.status)
                            $error("status exp %h got %h", e.status, res.status);
                        if (res.last !== e.last)
                            $error("last exp %h got %h", e.last, res.last);
                    end
                end
            end
        end
        pending = expected_replies.size();
    end
endmodule
`default_nettype wire

/* sim/xmodem_block_receiver_top_test.sv */
`default_nettype none
module xmodem_block_receiver_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import xbr_pkg::*;

    // Ways in which a generated block can be spoiled on purpose.
    typedef enum int {BLK_CLEAN, BLK_BAD_COMPLEMENT, BLK_BAD_CHECK} blk_fault_t;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   sent_items;
    int   burst_left;

    // The stimulus keeps its own view of the settings so it knows how many
    // ticks end a wait and which check to append to a block.
    logic        cur_crc;
    logic [23:0] cur_hdr_to;
    logic [23:0] cur_chr_to;
    logic [7:0]  cur_retry;
    logic [7:0]  next_seq;

    xbr_cmd_if          cmd_if();
    xbr_cfg_if          cfg_if();
    xbr_res_if #(24)    res_if();

    xmodem_block_receiver_top #(.OFFSET_BITS(24)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .cfg   (cfg_if),
        .res   (res_if)
    );

    xbr_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .cfg     (cfg_if),
        .res     (res_if),
        .fails   (fails),
        .pending (pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // A hard ceiling on the run, well past the slowest correct run.
    initial
    begin
        #20ms;
        $display("xmodem_block_receiver_top_test: FAIL");
        $finish;
    end

    // CRC in the usual table-free form: the byte enters at the top. Its value,
    // appended high byte first, leaves the receiver's remainder at zero.
    function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // Offer one item, keeping valid high across items inside a burst. Between
    // bursts valid drops for a random number of cycles.
    task automatic send_item(logic [1:0] m, logic [7:0] b);
        @(negedge clk);
        if (burst_left == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
            burst_left = ($urandom_range(3) == 0) ? 200 : $urandom_range(12, 1);
        end
        cmd_if.mode <= m;
        cmd_if.rx_byte <= b;
        cmd_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        burst_left--;
        sent_items++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(MODE_BYTE, b);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(MODE_TICK, 8'($urandom_range(255)));
    endtask

    task automatic write_reg(cfg_index_t idx, logic [23:0] value);
        @(negedge clk);
        cfg_if.index <= idx;
        cfg_if.data <= value;
        cfg_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Hold the sender back until every expected result has come out, then let
    // the block settle before any register changes.
    task automatic drain();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_all(logic crc, logic batch, logic [23:0] hdr, logic [23:0] chr,
                           logic [7:0] retry, logic [23:0] size);
        write_reg(CFG_CRC_MODE, {23'h0, crc});
        write_reg(CFG_YMODEM_BATCH, {23'h0, batch});
        write_reg(CFG_HDR_TIMEOUT, hdr);
        write_reg(CFG_CHAR_TIMEOUT, chr);
        write_reg(CFG_RETRY_MAX, {16'h0, retry});
        write_reg(CFG_EXPECTED_SIZE, size);
        cur_crc = crc;
        cur_hdr_to = hdr;
        cur_chr_to = chr;
        cur_retry = retry;
    endtask

    // Send one framed block with random payload and the check that the
    // current mode expects, unless a fault is asked for.
    task automatic send_block(logic [7:0] seq, logic long_b, blk_fault_t fault);
        logic [15:0] crc;
        logic [7:0]  sum;
        logic [7:0]  d;
        int          len;
        crc = 16'h0;
        sum = 8'h0;
        len = long_b ? 1024 : 128;
        send_byte(long_b ? B_STX : B_SOH);
        send_byte(seq);
        if (fault == BLK_BAD_COMPLEMENT)
        begin
            send_byte(~seq ^ (8'h1 << $urandom_range(7)));
            return;
        end
        send_byte(~seq);
        for (int i = 0; i < len; i++)
        begin
            d = 8'($urandom_range(255));
            crc = crc_next(crc, d);
            sum = sum + d;
            send_byte(d);
        end
        if (fault == BLK_BAD_CHECK)
        begin
            crc = crc ^ (16'h1 << $urandom_range(15));
            sum = sum ^ (8'h1 << $urandom_range(7));
        end
        if (cur_crc)
        begin
            send_byte(crc[15:8]);
            send_byte(crc[7:0]);
        end
        else
        begin
            send_byte(sum);
        end
    endtask

    // One transfer: a start, a block with a random fault, and one of several
    // endings. Flows that rely on waits expiring run only when the timeouts
    // are short.
    task automatic run_transfer(logic short_waits);
        int nblk;
        int pick;
        next_seq = 8'h01;
        send_item(MODE_START, 8'($urandom_range(255)));
        nblk = 1;
        for (int k = 0; k < nblk; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                send_block(next_seq, 1'b0, BLK_CLEAN);
                next_seq++;
            end
            else if (pick < 65)
            begin
                send_block(next_seq - 8'd1, 1'b0, BLK_CLEAN);
            end
            else if (pick < 75)
            begin
                send_block(next_seq + 8'($urandom_range(200, 2)), 1'b0, BLK_CLEAN);
            end
            else if (short_waits && pick < 87)
            begin
                send_block(next_seq, 1'b0,
                           ($urandom_range(1) != 0) ? BLK_BAD_CHECK : BLK_BAD_COMPLEMENT);
                send_ticks(cur_chr_to + 1);
            end
            else if (short_waits && pick < 94)
            begin
                // Stray byte in the header slot, or a missed header.
                if ($urandom_range(1) != 0)
                    send_byte(8'($urandom_range(255)));
                else
                    send_ticks(cur_hdr_to);
                send_ticks(cur_chr_to + 1);
            end
            else
            begin
                // Noise: unused mode and a lone CAN that restarts the try.
                send_item(MODE_UNUSED, 8'($urandom_range(255)));
                send_byte(B_CAN);
            end
        end
        pick = $urandom_range(99);
        if (short_waits && pick < 40)
        begin
            send_byte(B_EOT);
            send_ticks(cur_chr_to);
            send_byte(B_EOT);
        end
        else if (pick < 60)
        begin
            send_byte(B_CAN);
            send_byte(B_CAN);
        end
        else if (short_waits && cur_retry <= 8'd4 && pick < 80)
        begin
            // Let every try expire until the block gives up with four CANs.
            repeat (cur_retry + 2)
            begin
                send_ticks(cur_hdr_to);
                send_ticks(cur_chr_to);
            end
        end
        else if (pick < 90)
        begin
            // A start in the middle of a transfer begins it again.
            send_item(MODE_START, 8'($urandom_range(255)));
        end
    endtask

    // Receiver: stretches of always-ready, random stalls, and now and then a
    // long hold-off so the queue fills and the command side backs up.
    initial
    begin
        int stretch;
        int len;
        int kind;
        res_if.ready = 1'b0;
        stretch = 0;
        @(posedge rst_n);
        forever
        begin
            len = $urandom_range(80, 10);
            kind = $urandom_range(2);
            if (stretch % 7 == 3)
            begin
                for (int c = 0; c < 300; c++)
                begin
                    @(negedge clk);
                    res_if.ready <= 1'b0;
                end
            end
            else
            begin
                for (int c = 0; c < len; c++)
                begin
                    @(negedge clk);
                    case (kind)
                        0:       res_if.ready <= 1'b1;
                        1:       res_if.ready <= ($urandom_range(1) != 0);
                        default: res_if.ready <= ($urandom_range(3) == 0);
                    endcase
                end
            end
            stretch++;
        end
    end

    initial
    begin
        int ep;
        cmd_if.valid = 1'b0;
        cmd_if.mode = MODE_BYTE;
        cmd_if.rx_byte = 8'h00;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_CRC_MODE;
        cfg_if.data = 24'h0;
        sent_items = 0;
        burst_left = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: idle inputs, a missed header, a lone and a double
        // CAN, a clean double-EOT ending, a long block that stalls after its
        // first data byte, and a run that uses up its tries.
        set_all(1'b0, 1'b0, 24'd2, 24'd1, 8'd2, 24'h0);
        send_byte(8'hff);
        send_item(MODE_TICK, 8'h00);
        send_item(MODE_UNUSED, 8'hff);
        send_item(MODE_START, 8'h00);
        send_ticks(3);
        send_byte(B_CAN);
        send_byte(B_CAN);
        send_item(MODE_START, 8'h00);
        send_byte(B_EOT);
        send_ticks(1);
        send_byte(B_EOT);
        send_item(MODE_START, 8'h00);
        send_byte(B_STX);
        send_byte(8'h01);
        send_byte(8'hfe);
        send_byte(8'h55);
        send_ticks(2);
        send_byte(B_CAN);
        send_byte(B_CAN);
        send_item(MODE_START, 8'h00);
        send_ticks(8);
        drain();

        // Random part: one transfer per setting, extremes first.
        ep = 0;
        while (sent_items < 150)
        begin
            case (ep)
                0: set_all(1'b1, 1'b1, 24'd1, 24'd1, 8'd1, 24'h0);
                1: set_all(1'b0, 1'b0, 24'hffffff, 24'hffffff, 8'd255, 24'hffffff);
                2: set_all(1'b1, 1'b0, 24'd3, 24'd2, 8'd255, 24'd256);
                default: set_all(1'($urandom_range(1)), 1'($urandom_range(1)),
                                 24'($urandom_range(6, 1)), 24'($urandom_range(4, 1)),
                                 8'($urandom_range(4, 1)),
                                 ($urandom_range(1) != 0) ? 24'h0 : 24'($urandom_range(640)));
            endcase
            run_transfer(ep != 1);
            drain();
            ep++;
        end

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fails == 0)
            $display("xmodem_block_receiver_top_test: PASS");
        else
            $display("xmodem_block_receiver_top_test: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
